// ===== hw/rtl/overwrite_ring_with_read_cursor_assert.svh =====
// ----------------------------------------------------------------------------
// overwrite ring assertion macros
// shared concurrent assertion forms for the overwrite ring checker
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_RING_WITH_READ_CURSOR_ASSERT_SVH
`define OVERWRITE_RING_WITH_READ_CURSOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ORWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ORWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/orwc_pkg.sv =====
// ----------------------------------------------------------------------------
// orwc_pkg
// shared types and constants of the overwrite ring with read cursor
// ----------------------------------------------------------------------------
package orwc_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CFG_W      = 5;
    localparam int OP_W       = 2;

    localparam logic [CFG_W-1:0] MAX_SIZE_RST = 5'd16;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT      = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT_ONE = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT_ALL = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED    = 2'd3;

    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    // control broadcast along the cell row
    typedef struct packed {
        logic             shift;
        logic             load;
        logic [IDX_W-1:0] load_idx;
    } chain_ctl_t;

endpackage

// ===== hw/rtl/overwrite_ring_with_read_cursor.sv =====
// ----------------------------------------------------------------------------
// overwrite_ring_with_read_cursor
// history ring that overwrites its oldest word when full, read by a cursor
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with opcode and entry_data
//     insert appends a word, extract-one returns the word at the cursor,
//     extract-all returns every unread word oldest first, last on the final
//   output channel: out_valid / out_stall with entry_data_res, no_data, last
//   config: cfg_we writes cfg_data into max_size; the user writes only while the block is idle, unchecked
// timing
//   insert: no result
//   extract: result visible the cycle after acceptance
//   extract-all of n unread words: one word per cycle out of the output register
//     while out_stall is low; the drain sequencer holds the input off meanwhile
//   the cursor read is one mux over the cell row, so the word rate is set
//     by the output register draining at one item per cycle while out_stall is low
// reset
//   ring empty, cursor zero, max_size 16, no result pending; cell contents
//   are left as they are and never read before being written
// stall
//   a stalled result holds in the output register; input is held off only
//   while a result cannot move on or a drain is in progress
// ----------------------------------------------------------------------------
module overwrite_ring_with_read_cursor (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [orwc_pkg::OP_W-1:0]   opcode,
    input  logic [orwc_pkg::DATA_WIDTH-1:0] entry_data,
    // configuration
    input  logic                        cfg_we,
    input  logic [orwc_pkg::CFG_W-1:0]  cfg_data,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [orwc_pkg::DATA_WIDTH-1:0] entry_data_res,
    output logic                        no_data,
    output logic                        last
);
    import orwc_pkg::*;

    // cells hold the words oldest first, cell 0 is the oldest
    data_t            cell_data [DEPTH];
    chain_ctl_t       ctl;
    logic [IDX_W-1:0] rd_idx;
    data_t            rd_data;

    orwc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_data_res (entry_data_res),
        .no_data        (no_data),
        .last           (last),
        .rd_idx         (rd_idx),
        .rd_data        (rd_data),
        .ctl            (ctl)
    );

    // row of cells; on overwrite each cell other than the top and the loaded one takes its upper neighbor's word
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        data_t nb_data;

        if (i < DEPTH - 1)
        begin : g_mid
            assign nb_data = cell_data[i + 1];
        end
        else
        begin : g_top
            // top cell keeps its word; it is reloaded whenever it matters
            assign nb_data = cell_data[i];
        end

        orwc_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .pos     (IDX_W'(i)),
            .wr_data (entry_data),
            .nb_data (nb_data),
            .data    (cell_data[i])
        );
    end

    // cursor read, one address
    assign rd_data = cell_data[rd_idx];

endmodule

// ===== hw/rtl/orwc_cell.sv =====
// ----------------------------------------------------------------------------
// orwc_cell
// one entry of the ring: loads a new word or takes its upper neighbor's word
// ----------------------------------------------------------------------------
module orwc_cell (
    input  logic                   clk,
    input  orwc_pkg::chain_ctl_t   ctl,
    input  logic [orwc_pkg::IDX_W-1:0] pos,
    input  orwc_pkg::data_t        wr_data,
    input  orwc_pkg::data_t        nb_data,
    output orwc_pkg::data_t        data
);
    import orwc_pkg::*;

    data_t data_reg;
    data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.load && (ctl.load_idx == pos))
        begin
            data_next = wr_data;
        end
        else if (ctl.shift)
        begin
            data_next = nb_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/orwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// orwc_ctrl
// count, read cursor, capacity register, drain sequencer and output register
// ----------------------------------------------------------------------------
module orwc_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [orwc_pkg::OP_W-1:0]   opcode,
    input  logic                        cfg_we,
    input  logic [orwc_pkg::CFG_W-1:0]  cfg_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output orwc_pkg::data_t             entry_data_res,
    output logic                        no_data,
    output logic                        last,
    output logic [orwc_pkg::IDX_W-1:0]  rd_idx,
    input  orwc_pkg::data_t             rd_data,
    output orwc_pkg::chain_ctl_t        ctl
);
    import orwc_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  roff_reg, roff_next;
    logic [CFG_W-1:0]  max_size_reg;
    logic              out_valid_reg, out_valid_next;
    data_t             out_data_reg, out_data_next;
    logic              out_nd_reg, out_nd_next;
    logic              out_last_reg, out_last_next;

    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  roff_inc;
    logic              full;
    logic              has_unread;
    logic              last_unread;
    logic              out_free;
    logic              accept;

    // effective capacity: zero acts as one, clipped to the cell count
    always_comb
    begin
        if (max_size_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (int'(max_size_reg) > DEPTH)
        begin
            cap = CNT_W'(DEPTH);
        end
        else
        begin
            cap = CNT_W'(max_size_reg);
        end
    end

    assign roff_inc    = roff_reg + CNT_W'(1);
    assign full        = (count_reg >= cap);
    assign has_unread  = (roff_reg < count_reg);
    assign last_unread = (roff_inc == count_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign in_stall    = (state_reg == ST_DRAIN) || !out_free;
    assign accept      = in_valid && !in_stall;
    assign rd_idx      = roff_reg[IDX_W-1:0];

    always_comb
    begin : next_state
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_EXTRACT_ALL) && has_unread && !last_unread)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free && last_unread)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin : datapath
        count_next     = count_reg;
        roff_next      = roff_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        out_nd_next    = out_nd_reg;
        out_last_next  = out_last_reg;
        ctl            = '0;

        if (state_reg == ST_DRAIN)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_data;
                out_nd_next    = 1'b0;
                out_last_next  = last_unread;
                roff_next      = roff_inc;
            end
        end
        else if (accept)
        begin
            priority if (opcode == OP_INSERT)
            begin
                ctl.load = 1'b1;
                if (full)
                begin
                    // drop the oldest word, cursor follows it down
                    ctl.shift    = 1'b1;
                    ctl.load_idx = IDX_W'(count_reg - CNT_W'(1));
                    if (roff_reg != '0)
                    begin
                        roff_next = roff_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    ctl.load_idx = IDX_W'(count_reg);
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            else if ((opcode == OP_EXTRACT_ONE) || (opcode == OP_EXTRACT_ALL))
            begin
                out_valid_next = 1'b1;
                if (!has_unread)
                begin
                    out_data_next = '0;
                    out_nd_next   = 1'b1;
                    out_last_next = 1'b1;
                end
                else
                begin
                    out_data_next = rd_data;
                    out_nd_next   = 1'b0;
                    out_last_next = (opcode == OP_EXTRACT_ONE) || last_unread;
                    roff_next     = roff_inc;
                end
            end
            else
            begin
                // unused opcode, no result
                out_valid_next = out_valid_reg && out_stall;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            roff_reg      <= '0;
            max_size_reg  <= MAX_SIZE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            roff_reg      <= roff_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                max_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_nd_reg   <= out_nd_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign entry_data_res = out_data_reg;
    assign no_data        = out_nd_reg;
    assign last           = out_last_reg;

endmodule

// ===== hw/rtl/orwc_checker.sv =====
// ----------------------------------------------------------------------------
// orwc_checker
// port-level checks on the overwrite ring, bound to the top level
// ----------------------------------------------------------------------------
`include "overwrite_ring_with_read_cursor_assert.svh"

module orwc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [orwc_pkg::OP_W-1:0]   opcode,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [orwc_pkg::DATA_WIDTH-1:0] entry_data_res,
    input  logic                        no_data,
    input  logic                        last
);
    import orwc_pkg::*;

    // stalled result holds
    `ORWC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable({entry_data_res, no_data, last}),
        "stalled result changed")

    // an empty extract is a single zero item marked last
    `ORWC_ASSERT_NOW(a_nodata_form, clk, rst_n, out_valid && no_data,
        last && (entry_data_res == '0), "no-data result malformed")

    // insert into an idle output gives no item
    `ORWC_ASSERT_NEXT(a_insert_silent, clk, rst_n,
        in_valid && !in_stall && (opcode == OP_INSERT) && !out_valid,
        !out_valid, "insert produced an item")

    // extract-one always gives exactly one item, marked last, next cycle
    `ORWC_ASSERT_NEXT(a_one_last, clk, rst_n,
        in_valid && !in_stall && (opcode == OP_EXTRACT_ONE),
        out_valid && last, "extract-one item missing or not last")

endmodule

bind overwrite_ring_with_read_cursor orwc_checker u_orwc_checker (.*);

// ===== test/overwrite_ring_with_read_cursor_tb.sv =====
// ----------------------------------------------------------------------------
// overwrite_ring_with_read_cursor_tb
// self-checking bench for the overwriting history ring with read cursor:
// a queue-fed driver offers insert, extract and unused-opcode items with random gaps, a
// monitor keeps its own copy of the ring and the cursor, predicts every read,
// and compares each returned item field by field; max_size is changed
// between phases while the block is idle
// ----------------------------------------------------------------------------
module overwrite_ring_with_read_cursor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import orwc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 40;   // longest drain plus margin
    localparam int PHASE_ITEMS  = 22;

    // one item offered on the input channel
    typedef struct packed {
        logic [OP_W-1:0] op;
        data_t           data;
    } ring_op_t;

    // one item returned by an extract
    typedef struct packed {
        data_t word;
        logic  no_data;
        logic  last;
    } ring_read_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       opcode = '0;
    data_t                 entry_data = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    data_t                 entry_data_res;
    logic                  no_data;
    logic                  last;

    // bench control
    logic                  calm = 1'b0;       // no gaps and no new random stall bursts while set
    logic                  long_hold = 1'b0;  // receiver holds off completely
    int                    send_gap = 0;
    int                    stall_left = 0;
    int                    cycle_count = 0;
    int                    mismatches = 0;
    int                    ops_queued = 0;
    int                    ops_accepted = 0;

    ring_op_t              ops_to_send[$];
    ring_read_t            expected_reads[$];

    // predictor copy of the ring
    data_t                 ring_words[DEPTH];
    logic [IDX_W-1:0]      ring_oldest;
    logic [CNT_W-1:0]      ring_count;
    logic [CNT_W-1:0]      ring_cursor;
    logic [CFG_W-1:0]      ring_max;

    overwrite_ring_with_read_cursor dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .entry_data     (entry_data),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_data_res (entry_data_res),
        .no_data        (no_data),
        .last           (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // append one expected read at the tail of the scoreboard
    task automatic add_read(input data_t w, input logic nd, input logic lst);
        ring_read_t r;
        r = '{word: w, no_data: nd, last: lst};
        expected_reads.insert(expected_reads.size(), r);
    endtask

    // expected reads for one accepted item, state updated as the block does
    task automatic predict_ring_op(input logic [OP_W-1:0] op, input data_t data);
        logic [CNT_W-1:0] cap;
        logic [IDX_W-1:0] slot;
        cap = (ring_max == 0) ? CNT_W'(1) :
              (ring_max > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(ring_max);
        case (op)
            OP_INSERT:
            begin
                // full: drop the oldest word, cursor follows it but stays at zero
                if (ring_count >= cap)
                begin
                    ring_oldest = ring_oldest + 1'b1;
                    ring_count  = ring_count - 1'b1;
                    if (ring_cursor != 0)
                        ring_cursor = ring_cursor - 1'b1;
                end
                slot = ring_oldest + ring_count[IDX_W-1:0];
                ring_words[slot] = data;
                ring_count = ring_count + 1'b1;
            end
            OP_EXTRACT_ONE, OP_EXTRACT_ALL:
            begin
                if (ring_cursor >= ring_count)
                    add_read('0, 1'b1, 1'b1);
                else if (op == OP_EXTRACT_ONE)
                begin
                    slot = ring_oldest + ring_cursor[IDX_W-1:0];
                    add_read(ring_words[slot], 1'b0, 1'b1);
                    ring_cursor = ring_cursor + 1'b1;
                end
                else
                begin
                    // every unread word, oldest first, last on the final one
                    while (ring_cursor < ring_count)
                    begin
                        slot = ring_oldest + ring_cursor[IDX_W-1:0];
                        add_read(ring_words[slot], 1'b0,
                                 (ring_cursor + 1'b1 == ring_count));
                        ring_cursor = ring_cursor + 1'b1;
                    end
                end
            end
            default:
            begin
                // unused opcode: ignored, nothing returned
            end
        endcase
    endtask

    // driver: next item goes out once the current one is taken and the gap is over
    always @(posedge clk)
    begin
        ring_op_t next_op;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (ops_to_send.size() != 0)
            begin
                next_op = ops_to_send.pop_front();
                in_valid   <= 1'b1;
                opcode     <= next_op.op;
                entry_data <= next_op.data;
                send_gap   <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall: random bursts, forced high during the long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (long_hold)
            out_stall <= 1'b1;
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= pick_gap();
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: checks returned items, then predicts from the accepted item;
    // a read shows up in the cycle after its extract at the earliest, so the
    // order of the two inside one edge does not matter
    always @(posedge clk)
    begin
        ring_read_t want;
        if (!rst_n)
        begin
            ring_oldest = '0;
            ring_count  = '0;
            ring_cursor = '0;
            ring_max    = MAX_SIZE_RST;
            expected_reads.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reads.size() == 0)
                    report_mismatch($sformatf("unexpected item data=%h no_data=%b last=%b",
                                              entry_data_res, no_data, last));
                else
                begin
                    want = expected_reads.pop_front();
                    if (entry_data_res !== want.word)
                        report_mismatch($sformatf("entry_data_res %h, expected %h",
                                                  entry_data_res, want.word));
                    if (no_data !== want.no_data)
                        report_mismatch($sformatf("no_data %b, expected %b",
                                                  no_data, want.no_data));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b", last, want.last));
                end
            end
            // config writes only happen while idle
            if (cfg_we)
                ring_max = cfg_data;
            if (in_valid && !in_stall)
            begin
                predict_ring_op(opcode, entry_data);
                ops_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL overwrite_ring_with_read_cursor");
            $finish;
        end
    end

    // called at the falling edge so the driver never races the append
    task automatic queue_op(input logic [OP_W-1:0] op, input data_t data);
        ring_op_t pending;
        pending = '{op: op, data: data};
        ops_to_send.insert(ops_to_send.size(), pending);
        ops_queued++;
    endtask

    // everything taken, every read returned, then the drain latency
    task automatic wait_idle();
        @(negedge clk);
        while (ops_accepted != ops_queued || expected_reads.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_max_size(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    // mostly inserts so the ring fills and wraps, extracts often enough to
    // move the cursor and to hit the empty case, a few unused opcodes
    task automatic queue_random_ops(input int count);
        int    r;
        data_t d;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       d = '0;
                1:       d = '1;
                default: d = $urandom;
            endcase
            if (r < 50)
                queue_op(OP_INSERT, d);
            else if (r < 72)
                queue_op(OP_EXTRACT_ONE, d);
            else if (r < 94)
                queue_op(OP_EXTRACT_ALL, d);
            else
                queue_op(OP_RESERVED, d);
        end
    endtask

    initial
    begin
        // capacities visited by the random phases, both extremes and out of range
        logic [CFG_W-1:0] phase_caps[10] = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd2,
                                              5'd0, 5'd9, 5'd3, 5'd16, 5'd12};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty ring at reset size, extremes of the data word
        queue_op(OP_EXTRACT_ONE, 32'hFFFF_FFFF);
        queue_op(OP_EXTRACT_ALL, 32'h0000_0000);
        queue_op(OP_RESERVED, 32'h1234_5678);
        queue_op(OP_INSERT, 32'h0000_0000);
        queue_op(OP_INSERT, 32'hFFFF_FFFF);
        queue_op(OP_INSERT, 32'hA5A5_A5A5);
        queue_op(OP_INSERT, 32'h5A5A_5A5A);
        queue_op(OP_EXTRACT_ONE, 32'h0);
        queue_op(OP_EXTRACT_ALL, 32'h0);
        queue_op(OP_EXTRACT_ONE, 32'h0);
        wait_idle();

        // zero capacity acts as one: overwrite while full and unread
        write_max_size(5'd0);
        queue_op(OP_INSERT, 32'h8000_0000);
        queue_op(OP_INSERT, 32'h0000_0001);
        queue_op(OP_EXTRACT_ONE, 32'h0);
        queue_op(OP_EXTRACT_ALL, 32'h0);
        wait_idle();

        // oversize capacity acts as the full depth, then lowered below the count
        write_max_size(5'd31);
        queue_op(OP_INSERT, 32'h1111_1111);
        queue_op(OP_INSERT, 32'h2222_2222);
        queue_op(OP_INSERT, 32'h3333_3333);
        wait_idle();
        write_max_size(5'd2);
        queue_op(OP_INSERT, 32'h4444_4444);
        queue_op(OP_EXTRACT_ALL, 32'h0);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            write_max_size(phase_caps[p]);
            calm <= (p == 4);
            queue_random_ops(PHASE_ITEMS);
            wait_idle();

            // long receiver hold: the sender keeps offering until input stalls
            if (p == 2)
            begin
                write_max_size(5'd16);
                @(posedge clk);
                calm      <= 1'b1;
                long_hold <= 1'b1;
                @(negedge clk);
                for (int i = 0; i < 12; i++)
                    queue_op(OP_INSERT, $urandom);
                queue_op(OP_EXTRACT_ALL, 32'h0);
                queue_random_ops(30);
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold <= 1'b0;
                calm      <= 1'b0;
                wait_idle();
            end
        end

        // quiet tail so a stray late item cannot hide behind a stall
        @(posedge clk);
        calm <= 1'b1;
        wait_idle();

        if (mismatches == 0)
            $display("PASS overwrite_ring_with_read_cursor");
        else
            $display("FAIL overwrite_ring_with_read_cursor");
        $finish;
    end

endmodule
